@@ src/spmv_pkg.sv @@
// ----------------------------------------------------------------------------
// spmv_pkg: shared types and constants for the CSR sparse matrix-vector block
// Vector store size, field widths, command codes and inter-stage records.
// ----------------------------------------------------------------------------
package spmv_pkg;

  localparam int VEC_SIZE = 1024;
  localparam int VEC_AW   = (VEC_SIZE > 1) ? $clog2(VEC_SIZE) : 1;

  localparam int CMD_W = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_MAC  = 2'd1,
    CMD_EOR  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic                    eor;
    logic signed [SUM_W-1:0] prod;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_word_t;

endpackage

@@ src/spmv_in_if.sv @@
// ----------------------------------------------------------------------------
// spmv_in_if: command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface spmv_in_if
  import spmv_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

@@ src/spmv_out_if.sv @@
// ----------------------------------------------------------------------------
// spmv_out_if: row result channel
// Valid/ready channel carrying one finished row sum.
// ----------------------------------------------------------------------------
interface spmv_out_if
  import spmv_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] row_sum;
  logic                    saturated;

  modport source (output valid, output row_sum, output saturated, input ready);
  modport sink   (input valid, input row_sum, input saturated, output ready);
endinterface

@@ src/spmv_ram.sv @@
// ----------------------------------------------------------------------------
// spmv_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held until next read.
// ----------------------------------------------------------------------------
module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/spmv_front.sv @@
// ----------------------------------------------------------------------------
// spmv_front: command intake
// Accept commands, write loads to the vector store, read the column element
// for nonzeros and form the product for the queue.
// ----------------------------------------------------------------------------
module spmv_front
  import spmv_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  spmv_in_if.sink       in_ch,
  output q_word_t       push,
  input  logic          q_full
);

  logic                    accept;
  logic                    in_range;
  logic [VEC_AW+IDX_W-1:0] addr_wide;
  logic [VEC_AW-1:0]       addr;
  logic                    is_load;
  logic                    is_mac;
  logic                    is_eor;
  logic [VAL_W-1:0]        rdata;
  logic signed [VAL_W-1:0] elem;
  logic signed [SUM_W-1:0] prod;

  logic                    f_valid_r, f_valid_nxt;
  logic                    f_eor_r;
  logic                    f_inr_r;
  logic signed [VAL_W-1:0] f_val_r;

  assign addr_wide = {{VEC_AW{1'b0}}, in_ch.index};
  assign addr      = addr_wide[VEC_AW-1:0];
  assign in_range  = 32'(in_ch.index) < 32'(VEC_SIZE);

  assign is_load = in_ch.cmd == CMD_LOAD;
  assign is_mac  = in_ch.cmd == CMD_MAC;
  assign is_eor  = in_ch.cmd == CMD_EOR;

  assign in_ch.ready = !f_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  spmv_ram #(
    .WIDTH(VAL_W),
    .DEPTH(VEC_SIZE)
  ) u_vec_ram (
    .clk  (clk),
    .we   (accept && is_load && in_range),
    .waddr(addr),
    .wdata(in_ch.value),
    .re   (accept && is_mac),
    .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (f_valid_r && !q_full) begin
      f_valid_nxt = 1'b0;
    end
    if (accept && (is_mac || is_eor)) begin
      f_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_eor_r <= is_eor;
      f_inr_r <= in_range;
      f_val_r <= in_ch.value;
    end
  end

  assign elem = f_inr_r ? $signed(rdata) : '0;
  assign prod = f_val_r * elem;

  always_comb begin
    push.valid      = f_valid_r && !q_full;
    push.entry.eor  = f_eor_r;
    push.entry.prod = prod;
  end

endmodule

@@ src/spmv_queue.sv @@
// ----------------------------------------------------------------------------
// spmv_queue: decoupling queue
// Short FIFO of products and row-end markers between intake and accumulator.
// ----------------------------------------------------------------------------
module spmv_queue
  import spmv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_word_t push,
  output logic    full,
  output q_word_t head,
  input  logic    pop
);

  q_entry_t       q_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_pop;

  assign full       = cnt_r == (QAW+1)'(QDEPTH);
  assign head.valid = cnt_r != '0;
  assign head.entry = q_r[rptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wptr_nxt = push.valid ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QAW+1)'(push.valid) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_r[wptr_r] <= push.entry;
    end
  end

endmodule

@@ src/spmv_back.sv @@
// ----------------------------------------------------------------------------
// spmv_back: row accumulator
// Add products into the saturating row sum and emit the sum at row end.
// ----------------------------------------------------------------------------
module spmv_back
  import spmv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_word_t head,
  output logic    pop,
  spmv_out_if.source out_ch
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic                    sat_r, sat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_sat_r;
  logic signed [SUM_W-1:0] sum;
  logic                    ovf;
  logic                    pop_mac;
  logic                    pop_eor;

  assign pop     = head.valid && (!head.entry.eor || !out_valid_r || out_ch.ready);
  assign pop_mac = pop && !head.entry.eor;
  assign pop_eor = pop && head.entry.eor;

  assign sum = acc_r + head.entry.prod;
  assign ovf = (acc_r[SUM_W-1] == head.entry.prod[SUM_W-1]) &&
               (sum[SUM_W-1] != acc_r[SUM_W-1]);

  always_comb begin
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop_mac) begin
      if (ovf) begin
        acc_nxt = head.entry.prod[SUM_W-1] ? SUM_MIN : SUM_MAX;
        sat_nxt = 1'b1;
      end else begin
        acc_nxt = sum;
      end
    end
    if (pop_eor) begin
      acc_nxt       = '0;
      sat_nxt       = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_eor) begin
      out_sum_r <= acc_r;
      out_sat_r <= sat_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_sum   = out_sum_r;
  assign out_ch.saturated = out_sat_r;

endmodule

@@ src/csr_sparse_matrix_vector_multiply.sv @@
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply: CSR sparse matrix times dense vector
// Loads fill the vector store, nonzeros accumulate Q16.16 x Q16.16 products
// into a saturating Q32.32 row sum, row-end commands emit the sum.
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | cmd, index, value
//   out_ch   | out | valid/ready        | row_sum, saturated
//
// One command per cycle while the queue is not full. A nonzero passes the
// vector store read, the multiply into the queue and the add to the row sum.
// Reset is synchronous, active low; the vector store is not cleared.
// A stalled output backs up the 4-entry queue, then drops in_ch.ready.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply
  import spmv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spmv_in_if.sink    in_ch,
  spmv_out_if.source out_ch
);

  q_word_t push;
  q_word_t head;
  logic    q_full;
  logic    pop;

  spmv_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .push  (push),
    .q_full(q_full)
  );

  spmv_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  spmv_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

@@ tb/tb_csr_sparse_matrix_vector_multiply.sv @@
// ----------------------------------------------------------------------------
// tb_csr_sparse_matrix_vector_multiply: self-checking bench for the SpMV block
// Streams vector loads, nonzero words and row ends through the command channel.
// A scoreboard class predicts each saturating Q32.32 row sum and checks every
// row word in order. The sender runs in random bursts and the receiver stalls
// on its own pattern.
// ----------------------------------------------------------------------------
module tb_csr_sparse_matrix_vector_multiply;
  import spmv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam int RANDOM_WORDS = 1800;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } cmd_word_t;

  typedef struct {
    logic signed [SUM_W-1:0] row_sum;
    logic                    saturated;
  } row_result_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

  class row_sum_scoreboard;
    logic signed [VAL_W-1:0] vec_elem [VEC_SIZE];
    logic signed [SUM_W-1:0] acc;
    logic                    acc_sat;
    row_result_t             pending_rows [$];
    int                      errors;

    function new();
      acc = '0;
      acc_sat = 1'b0;
      errors = 0;
    endfunction

    function void note_word(cmd_word_t w);
      logic signed [SUM_W-1:0] a;
      logic signed [SUM_W-1:0] b;
      logic signed [SUM_W-1:0] prod;
      logic signed [SUM_W-1:0] sum;
      row_result_t r;
      case (w.cmd)
        CMD_LOAD: begin
          if (w.index < VEC_SIZE) vec_elem[w.index] = w.value;
        end
        CMD_MAC: begin
          a = SUM_W'(w.value);
          b = (w.index < VEC_SIZE) ? SUM_W'(vec_elem[w.index]) : '0;
          prod = a * b;
          sum = acc + prod;
          if (acc[SUM_W-1] == prod[SUM_W-1] && sum[SUM_W-1] != acc[SUM_W-1]) begin
            sum = prod[SUM_W-1] ? SUM_MIN : SUM_MAX;
            acc_sat = 1'b1;
          end
          acc = sum;
        end
        CMD_EOR: begin
          r.row_sum = acc;
          r.saturated = acc_sat;
          pending_rows.push_back(r);
          acc = '0;
          acc_sat = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_row(logic signed [SUM_W-1:0] row_sum, logic saturated);
      row_result_t r;
      if (pending_rows.size() == 0) begin
        $display("%0t unexpected row word: row_sum %h saturated %b",
                 $time, row_sum, saturated);
        errors++;
        return;
      end
      r = pending_rows.pop_front();
      if (row_sum !== r.row_sum) begin
        $display("%0t row_sum mismatch: expected %h actual %h", $time, r.row_sum, row_sum);
        errors++;
      end
      if (saturated !== r.saturated) begin
        $display("%0t saturated mismatch: expected %b actual %b",
                 $time, r.saturated, saturated);
        errors++;
      end
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;

  spmv_in_if  in_ch ();
  spmv_out_if out_ch ();

  csr_sparse_matrix_vector_multiply DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  row_sum_scoreboard rows = new();
  cmd_word_t         cmd_words [$];
  bit                loaded [VEC_SIZE];
  int                loaded_idx [$];

  rx_mode_t rx_mode = RX_OPEN;
  int       stall_left = 0;
  int       rx_cycle = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 128 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(4, 24);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) rows.check_row(out_ch.row_sum, out_ch.saturated);
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return -32'sd1;
      3: return 32'sd1;
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] index,
                                   logic signed [VAL_W-1:0] value);
    cmd_word_t w;
    w.cmd = cmd;
    w.index = index;
    w.value = value;
    cmd_words.push_back(w);
    if (cmd == CMD_LOAD && !loaded[index]) begin
      loaded[index] = 1'b1;
      loaded_idx.push_back(int'(index));
    end
  endfunction

  function automatic void build_directed();
    add_word(CMD_LOAD, 10'd0, VAL_MIN);
    add_word(CMD_LOAD, 10'd1023, VAL_MAX);
    add_word(CMD_LOAD, 10'd1, -32'sd1);
    add_word(CMD_LOAD, 10'd2, '0);
    add_word(CMD_EOR, 10'd0, '0);
    add_word(CMD_MAC, 10'd0, VAL_MIN);
    add_word(CMD_MAC, 10'd0, VAL_MIN);
    add_word(CMD_MAC, 10'd1023, VAL_MIN);
    add_word(CMD_EOR, 10'd1023, VAL_MAX);
    add_word(CMD_MAC, 10'd1023, VAL_MIN);
    add_word(CMD_MAC, 10'd1023, VAL_MIN);
    add_word(CMD_MAC, 10'd1023, VAL_MIN);
    add_word(CMD_MAC, 10'd2, VAL_MAX);
    add_word(CMD_EOR, 10'd0, VAL_MIN);
    add_word(CMD_MAC, 10'd1, VAL_MAX);
    add_word(CMD_MAC, 10'd1023, VAL_MAX);
    add_word(CMD_UNUSED, 10'd1023, VAL_MIN);
    add_word(CMD_LOAD, 10'd1023, 32'sd1);
    add_word(CMD_MAC, 10'd1023, -32'sd1);
    add_word(CMD_UNUSED, 10'd0, '0);
    add_word(CMD_EOR, 10'd512, -32'sd1);
  endfunction

  function automatic void build_random();
    int counted;
    int n_mac;
    int hot_idx;
    bit hot;
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      hot = ($urandom_range(0, 5) == 0);
      n_mac = $urandom_range(0, 8);
      if (hot) begin
        hot_idx = $urandom_range(0, VEC_SIZE - 1);
        add_word(CMD_LOAD, IDX_W'(hot_idx), $urandom_range(0, 1) ? VAL_MIN : VAL_MAX);
        counted++;
      end
      repeat (n_mac) begin
        if ($urandom_range(0, 4) == 0) begin
          add_word(CMD_LOAD, IDX_W'($urandom_range(0, VEC_SIZE - 1)), pick_value());
          counted++;
        end
        if ($urandom_range(0, 19) == 0) add_word(CMD_UNUSED, IDX_W'($urandom), $urandom);
        if (hot)
          add_word(CMD_MAC, IDX_W'(hot_idx), $urandom_range(0, 1) ? VAL_MIN : VAL_MAX);
        else
          add_word(CMD_MAC, IDX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]),
                   pick_value());
        counted++;
      end
      add_word(CMD_EOR, IDX_W'($urandom), $urandom);
      counted++;
    end
  endfunction

  task automatic send_word(input cmd_word_t w);
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= w.cmd;
    in_ch.index <= w.index;
    in_ch.value <= w.value;
    do @(posedge clk); while (!in_ch.ready);
    rows.note_word(w);
  endtask

  initial begin
    int i;
    int burst;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_LOAD;
    in_ch.index  <= '0;
    in_ch.value  <= '0;
    build_directed();
    build_random();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    i = 0;
    while (i < cmd_words.size()) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && i < cmd_words.size()) begin
        send_word(cmd_words[i]);
        i++;
        burst--;
      end
      if (i % 400 >= 80 && $urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    while (rows.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rows.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
